@@ rtl/core/dhcp_pkg.sv @@
package dhcp_pkg;

    // Protocol constants checked on every received reply.
    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_UDP        = 8'd17;
    localparam logic [15:0] PORT_SERVER      = 16'd67;
    localparam logic [7:0]  BOOT_REPLY       = 8'd2;
    localparam logic [7:0]  TAG_MSG_TYPE     = 8'd53;
    localparam logic [7:0]  TAG_SERVER_ID    = 8'd54;
    localparam logic [7:0]  MSG_OFFER        = 8'd2;
    localparam logic [7:0]  MSG_ACK          = 8'd5;
    localparam logic [7:0]  MSG_NAK          = 8'd6;

    // Configuration register layout.
    localparam int          POLL_W           = 22;
    localparam int          CFG_DATA_W       = 32;
    localparam int          CFG_INDEX_W      = 1;
    localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 22'd2000000;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POLL_LIMIT = 1'b0,
        CFG_START_XID  = 1'b1
    } cfg_index_t;

    // Input item operations.
    typedef enum logic {
        OP_START = 1'b0,
        OP_POLL  = 1'b1
    } op_t;

    // Transaction phase.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_OFFER = 2'd1,
        PH_ACK   = 2'd2
    } phase_t;

    // Result actions.
    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_DISCOVER = 3'd1,
        ACT_REQUEST  = 3'd2,
        ACT_BOUND    = 3'd3,
        ACT_FAILED   = 3'd4
    } action_t;

    // Decoded view of one received frame.
    typedef struct packed {
        logic        reply_ok;
        logic        is_offer;
        logic        is_ack;
        logic        is_nak;
        logic        addr_zero;
        logic [31:0] server;
    } check_t;

    // One result item.
    typedef struct packed {
        action_t     action;
        logic [31:0] tx_xid;
        logic [31:0] requested_addr;
        logic [31:0] server_addr;
        logic [31:0] bound_addr;
    } result_t;

endpackage

@@ rtl/core/dhcp_reply_check.sv @@
module dhcp_reply_check
    import dhcp_pkg::*;
(
    input  logic [15:0] ether_type,
    input  logic [7:0]  ip_protocol,
    input  logic [15:0] udp_source_port,
    input  logic [7:0]  boot_op,
    input  logic [31:0] rx_xid,
    input  logic [7:0]  first_option_tag,
    input  logic [7:0]  message_type,
    input  logic [31:0] your_addr,
    input  logic [31:0] next_server_addr,
    input  logic [7:0]  second_option_tag,
    input  logic [31:0] server_id_option,
    input  logic [31:0] current_xid,
    output check_t      check
);

    // A reply must be an IPv4 UDP frame from the server port carrying our id.
    always_comb
    begin
        check.reply_ok  = (ether_type == ETHERTYPE_IPV4) && (ip_protocol == PROTO_UDP) &&
                          (udp_source_port == PORT_SERVER) && (boot_op == BOOT_REPLY) &&
                          (rx_xid == current_xid) && (first_option_tag == TAG_MSG_TYPE);
        check.is_offer  = (message_type == MSG_OFFER);
        check.is_ack    = (message_type == MSG_ACK);
        check.is_nak    = (message_type == MSG_NAK);
        check.addr_zero = (your_addr == 32'd0);

        // Fall back to the server identifier option when siaddr is empty.
        if ((next_server_addr == 32'd0) && (second_option_tag == TAG_SERVER_ID))
        begin
            check.server = server_id_option;
        end
        else
        begin
            check.server = next_server_addr;
        end
    end

endmodule

@@ rtl/core/dhcp_fsm.sv @@
module dhcp_fsm
    import dhcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic              op,
    input  logic [31:0]       your_addr,
    input  check_t            check,
    input  logic [POLL_W-1:0] poll_limit,
    input  logic [31:0]       start_xid,
    output logic [31:0]       current_xid,
    output result_t           result
);

    phase_t            phase_reg, phase_next;
    logic [31:0]       xid_reg, xid_next;
    logic [31:0]       offered_reg, offered_next;
    logic [31:0]       server_reg, server_next;
    logic [POLL_W-1:0] count_reg, count_next;
    logic [POLL_W-1:0] limit;
    logic [POLL_W-1:0] count_inc;
    logic [31:0]       xid_inc;
    logic              waiting;

    assign current_xid = xid_reg;
    assign limit       = (poll_limit == '0) ? POLL_W'(1) : poll_limit;
    assign count_inc   = count_reg + POLL_W'(1);
    assign xid_inc     = xid_reg + 32'd1;

    // State registers advance only when an item is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            xid_reg     <= '0;
            offered_reg <= '0;
            server_reg  <= '0;
            count_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            xid_reg     <= xid_next;
            offered_reg <= offered_next;
            server_reg  <= server_next;
            count_reg   <= count_next;
        end
    end

    // Next state and the result for the current item.
    always_comb
    begin
        phase_next   = phase_reg;
        xid_next     = xid_reg;
        offered_next = offered_reg;
        server_next  = server_reg;
        count_next   = count_reg;
        result       = '{ACT_NONE, 32'd0, 32'd0, 32'd0, 32'd0};

        case (phase_reg)
            PH_OFFER, PH_ACK: waiting = 1'b1;
            default:          waiting = 1'b0;
        endcase

        if (op == OP_START)
        begin
            // A start abandons any running transaction.
            phase_next    = PH_OFFER;
            xid_next      = start_xid;
            offered_next  = '0;
            server_next   = '0;
            count_next    = '0;
            result.action = ACT_DISCOVER;
            result.tx_xid = start_xid;
        end
        else if (waiting)
        begin
            if (check.reply_ok && (phase_reg == PH_OFFER) && check.is_offer)
            begin
                if (check.addr_zero)
                begin
                    phase_next    = PH_IDLE;
                    count_next    = '0;
                    result.action = ACT_FAILED;
                end
                else
                begin
                    phase_next            = PH_ACK;
                    xid_next              = xid_inc;
                    offered_next          = your_addr;
                    server_next           = check.server;
                    count_next            = '0;
                    result.action         = ACT_REQUEST;
                    result.tx_xid         = xid_inc;
                    result.requested_addr = your_addr;
                    result.server_addr    = check.server;
                end
            end
            else if (check.reply_ok && (phase_reg == PH_ACK) &&
                     (check.is_ack || check.is_nak))
            begin
                phase_next = PH_IDLE;
                count_next = '0;
                if (check.is_ack && !check.addr_zero)
                begin
                    result.action     = ACT_BOUND;
                    result.bound_addr = your_addr;
                end
                else
                begin
                    result.action = ACT_FAILED;
                end
            end
            else if (count_inc >= limit)
            begin
                // The poll budget of this phase is spent.
                phase_next    = PH_IDLE;
                count_next    = '0;
                result.action = ACT_FAILED;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

endmodule

@@ rtl/core/dhcp_client_handshake.sv @@
// DHCP client handshake engine.
// The input channel (in_valid / in_stall) takes one request per item: op 0
// starts a transaction, op 1 delivers one receive poll with the reply fields
// pre-parsed from the frame (all zeros for an empty poll). Every item gives
// exactly one result on the output channel (out_valid / out_stall): the
// action to take plus the transaction id and addresses that go with it.
// Configuration is written through cfg_we / cfg_index / cfg_data: index 0 is
// the poll limit per waiting phase, index 1 the starting transaction id.
// An item is captured in the input register, then the reply check and phase
// update load the result register. Throughput is one item per cycle while
// the receiver does not stall; the phase and id registers are updated in
// the same cycle as the result, so a following item sees them at once.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; in_stall rises once both are full.
// Reset clears the phase to idle, the id, addresses and poll count to zero,
// the poll limit to 2000000 and the starting id to zero.
module dhcp_client_handshake
    import dhcp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   op,
    input  logic [15:0]            ether_type,
    input  logic [7:0]             ip_protocol,
    input  logic [15:0]            udp_source_port,
    input  logic [7:0]             boot_op,
    input  logic [31:0]            rx_xid,
    input  logic [7:0]             first_option_tag,
    input  logic [7:0]             message_type,
    input  logic [31:0]            your_addr,
    input  logic [31:0]            next_server_addr,
    input  logic [7:0]             second_option_tag,
    input  logic [31:0]            server_id_option,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             action,
    output logic [31:0]            tx_xid,
    output logic [31:0]            requested_addr,
    output logic [31:0]            server_addr,
    output logic [31:0]            bound_addr
);

    logic              limit_we;
    logic [POLL_W-1:0] limit_reg;
    logic [31:0]       start_xid_reg;

    logic             s1_valid_reg;
    logic             op_reg;
    logic [15:0]      ether_type_reg;
    logic [7:0]       ip_protocol_reg;
    logic [15:0]      udp_source_port_reg;
    logic [7:0]       boot_op_reg;
    logic [31:0]      rx_xid_reg;
    logic [7:0]       first_option_tag_reg;
    logic [7:0]       message_type_reg;
    logic [31:0]      your_addr_reg;
    logic [31:0]      next_server_addr_reg;
    logic [7:0]       second_option_tag_reg;
    logic [31:0]      server_id_option_reg;

    logic             out_valid_reg;
    result_t          result_reg;

    logic             advance;
    logic             fire;
    logic [31:0]      current_xid;
    check_t           check;
    result_t          result_next;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    // Configuration registers.
    assign limit_we = cfg_we && (cfg_index == CFG_POLL_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= POLL_LIMIT_RESET;
            start_xid_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (limit_we)
            begin
                limit_reg <= cfg_data[POLL_W-1:0];
            end
            else
            begin
                start_xid_reg <= cfg_data;
            end
        end
    end

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            op_reg                <= op;
            ether_type_reg        <= ether_type;
            ip_protocol_reg       <= ip_protocol;
            udp_source_port_reg   <= udp_source_port;
            boot_op_reg           <= boot_op;
            rx_xid_reg            <= rx_xid;
            first_option_tag_reg  <= first_option_tag;
            message_type_reg      <= message_type;
            your_addr_reg         <= your_addr;
            next_server_addr_reg  <= next_server_addr;
            second_option_tag_reg <= second_option_tag;
            server_id_option_reg  <= server_id_option;
        end
    end

    // Reply decode.
    dhcp_reply_check u_check (
        .ether_type        (ether_type_reg),
        .ip_protocol       (ip_protocol_reg),
        .udp_source_port   (udp_source_port_reg),
        .boot_op           (boot_op_reg),
        .rx_xid            (rx_xid_reg),
        .first_option_tag  (first_option_tag_reg),
        .message_type      (message_type_reg),
        .your_addr         (your_addr_reg),
        .next_server_addr  (next_server_addr_reg),
        .second_option_tag (second_option_tag_reg),
        .server_id_option  (server_id_option_reg),
        .current_xid       (current_xid),
        .check             (check)
    );

    // Transaction state and result selection.
    dhcp_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .op          (op_reg),
        .your_addr   (your_addr_reg),
        .check       (check),
        .poll_limit  (limit_reg),
        .start_xid   (start_xid_reg),
        .current_xid (current_xid),
        .result      (result_next)
    );

    // Result register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign action         = result_reg.action;
    assign tx_xid         = result_reg.tx_xid;
    assign requested_addr = result_reg.requested_addr;
    assign server_addr    = result_reg.server_addr;
    assign bound_addr     = result_reg.bound_addr;

endmodule

@@ sim/dhcp_client_handshake_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the DHCP client engine, tracks the client state
// and the register settings on its own, and compares each result.
module dhcp_client_handshake_checker
    import dhcp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   op,
    input  logic [15:0]            ether_type,
    input  logic [7:0]             ip_protocol,
    input  logic [15:0]            udp_source_port,
    input  logic [7:0]             boot_op,
    input  logic [31:0]            rx_xid,
    input  logic [7:0]             first_option_tag,
    input  logic [7:0]             message_type,
    input  logic [31:0]            your_addr,
    input  logic [31:0]            next_server_addr,
    input  logic [7:0]             second_option_tag,
    input  logic [31:0]            server_id_option,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [2:0]             action,
    input  logic [31:0]            tx_xid,
    input  logic [31:0]            requested_addr,
    input  logic [31:0]            server_addr,
    input  logic [31:0]            bound_addr,
    output int                     mismatches,
    output int                     outstanding,
    output int                     live_seen,
    output int                     leases_bound,
    output int                     leases_failed,
    output int                     requests_sent
);

    // Shadow copy of the registers and the client state.
    logic [POLL_W-1:0] limit_m;
    logic [31:0]       base_xid_m;
    phase_t            phase_m;
    logic [31:0]       xid_m;
    logic [31:0]       offer_m;
    logic [31:0]       server_m;
    logic [POLL_W-1:0] polls_m;

    // Results still owed by the engine, oldest first.
    result_t expected_results[$];

    int error_total;
    int live_total;
    int bound_total;
    int failed_total;
    int request_total;

    // Advance the client by one request and return the result it must give.
    function automatic result_t client_step(
        input logic        kind,
        input logic [15:0] etype,
        input logic [7:0]  proto,
        input logic [15:0] sport,
        input logic [7:0]  bop,
        input logic [31:0] rxid,
        input logic [7:0]  tag1,
        input logic [7:0]  mtype,
        input logic [31:0] yaddr,
        input logic [31:0] saddr,
        input logic [7:0]  tag2,
        input logic [31:0] sid
    );
        result_t           r;
        logic              reply;
        logic [POLL_W-1:0] budget;
        r = '0;
        if (kind == OP_START) begin
            // A start always opens a fresh transaction, whatever the phase.
            xid_m    = base_xid_m;
            offer_m  = '0;
            server_m = '0;
            polls_m  = '0;
            phase_m  = PH_OFFER;
            r.action = ACT_DISCOVER;
            r.tx_xid = xid_m;
        end
        else if (phase_m == PH_OFFER || phase_m == PH_ACK) begin
            reply = etype == ETHERTYPE_IPV4 && proto == PROTO_UDP &&
                    sport == PORT_SERVER && bop == BOOT_REPLY &&
                    rxid == xid_m && tag1 == TAG_MSG_TYPE;
            if (reply && phase_m == PH_OFFER && mtype == MSG_OFFER) begin
                if (yaddr == 32'd0) begin
                    phase_m  = PH_IDLE;
                    polls_m  = '0;
                    r.action = ACT_FAILED;
                end
                else begin
                    // The server address falls back to option 54 when siaddr is zero.
                    offer_m  = yaddr;
                    server_m = saddr;
                    if (server_m == 32'd0 && tag2 == TAG_SERVER_ID)
                        server_m = sid;
                    xid_m            = xid_m + 32'd1;
                    polls_m          = '0;
                    phase_m          = PH_ACK;
                    r.action         = ACT_REQUEST;
                    r.tx_xid         = xid_m;
                    r.requested_addr = offer_m;
                    r.server_addr    = server_m;
                end
            end
            else if (reply && phase_m == PH_ACK &&
                     (mtype == MSG_ACK || mtype == MSG_NAK)) begin
                phase_m = PH_IDLE;
                polls_m = '0;
                if (mtype == MSG_ACK && yaddr != 32'd0) begin
                    r.action     = ACT_BOUND;
                    r.bound_addr = yaddr;
                end
                else
                    r.action = ACT_FAILED;
            end
            else begin
                // Any undecided poll spends budget; a limit of zero acts as one.
                budget = limit_m;
                if (budget == '0)
                    budget = POLL_W'(1);
                polls_m = polls_m + POLL_W'(1);
                if (polls_m >= budget) begin
                    phase_m  = PH_IDLE;
                    polls_m  = '0;
                    r.action = ACT_FAILED;
                end
            end
        end
        return r;
    endfunction

    // Print one line per mismatch and count them all.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_total++;
        $display("%0t ns: mismatch on %s: got %h, expected %h",
                 $time, what, got, want);
    endtask

    // Sample all channels at the clock edge; exported counts use
    // nonblocking updates so the stimulus side reads settled values.
    always @(posedge clk or negedge rst_n) begin
        result_t want;
        result_t next;
        logic    live;
        if (!rst_n) begin
            limit_m       = POLL_LIMIT_RESET;
            base_xid_m    = '0;
            phase_m       = PH_IDLE;
            xid_m         = '0;
            offer_m       = '0;
            server_m      = '0;
            polls_m       = '0;
            error_total   = 0;
            live_total    = 0;
            bound_total   = 0;
            failed_total  = 0;
            request_total = 0;
            expected_results.delete();
            mismatches    <= 0;
            outstanding   <= 0;
            live_seen     <= 0;
            leases_bound  <= 0;
            leases_failed <= 0;
            requests_sent <= 0;
        end
        else begin
            // Register writes take effect at once.
            if (cfg_we) begin
                if (cfg_index == CFG_POLL_LIMIT)
                    limit_m = cfg_data[POLL_W-1:0];
                else if (cfg_index == CFG_START_XID)
                    base_xid_m = cfg_data;
            end

            // Compare a delivered result with the oldest expectation.
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result, action", 32'(action), '0);
                else begin
                    want = expected_results.pop_front();
                    if (action !== want.action)
                        report_mismatch("action", 32'(action), 32'(want.action));
                    if (tx_xid !== want.tx_xid)
                        report_mismatch("tx_xid", tx_xid, want.tx_xid);
                    if (requested_addr !== want.requested_addr)
                        report_mismatch("requested_addr", requested_addr,
                                        want.requested_addr);
                    if (server_addr !== want.server_addr)
                        report_mismatch("server_addr", server_addr, want.server_addr);
                    if (bound_addr !== want.bound_addr)
                        report_mismatch("bound_addr", bound_addr, want.bound_addr);
                end
            end

            // Predict the result of an accepted request.
            if (in_valid && !in_stall) begin
                live = op == OP_START || phase_m == PH_OFFER || phase_m == PH_ACK;
                next = client_step(op, ether_type, ip_protocol, udp_source_port,
                                   boot_op, rx_xid, first_option_tag, message_type,
                                   your_addr, next_server_addr, second_option_tag,
                                   server_id_option);
                expected_results.push_back(next);
                if (live)
                    live_total++;
                if (next.action == ACT_BOUND)
                    bound_total++;
                if (next.action == ACT_FAILED)
                    failed_total++;
                if (next.action == ACT_REQUEST)
                    request_total++;
            end

            mismatches    <= error_total;
            outstanding   <= expected_results.size();
            live_seen     <= live_total;
            leases_bound  <= bound_total;
            leases_failed <= failed_total;
            requests_sent <= request_total;
        end
    end

endmodule

@@ sim/dhcp_client_handshake_tb.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the DHCP client engine; checking lives in the
// checker instance beside the engine.
module dhcp_client_handshake_tb;
    import dhcp_pkg::*;

    // One request on the input channel.
    typedef struct {
        logic        op;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [15:0] udp_source_port;
        logic [7:0]  boot_op;
        logic [31:0] rx_xid;
        logic [7:0]  first_option_tag;
        logic [7:0]  message_type;
        logic [31:0] your_addr;
        logic [31:0] next_server_addr;
        logic [7:0]  second_option_tag;
        logic [31:0] server_id_option;
    } dhcp_item_t;

    logic                   clk;
    logic                   rst_n             = 1'b0;
    logic                   cfg_we            = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index         = '0;
    logic [CFG_DATA_W-1:0]  cfg_data          = '0;
    logic                   in_valid          = 1'b0;
    logic                   in_stall;
    logic                   op                = 1'b0;
    logic [15:0]            ether_type        = '0;
    logic [7:0]             ip_protocol       = '0;
    logic [15:0]            udp_source_port   = '0;
    logic [7:0]             boot_op           = '0;
    logic [31:0]            rx_xid            = '0;
    logic [7:0]             first_option_tag  = '0;
    logic [7:0]             message_type      = '0;
    logic [31:0]            your_addr         = '0;
    logic [31:0]            next_server_addr  = '0;
    logic [7:0]             second_option_tag = '0;
    logic [31:0]            server_id_option  = '0;
    logic                   out_valid;
    logic                   out_stall         = 1'b0;
    logic [2:0]             action;
    logic [31:0]            tx_xid;
    logic [31:0]            requested_addr;
    logic [31:0]            server_addr;
    logic [31:0]            bound_addr;

    int mismatches;
    int outstanding;
    int live_seen;
    int leases_bound;
    int leases_failed;
    int requests_sent;

    // When set, neither side idles or stalls.
    logic        calm             = 1'b0;
    logic [31:0] start_xid_now    = '0;
    int          settings_written = 0;
    int unsigned stall_left       = 0;

    dhcp_client_handshake dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .op                (op),
        .ether_type        (ether_type),
        .ip_protocol       (ip_protocol),
        .udp_source_port   (udp_source_port),
        .boot_op           (boot_op),
        .rx_xid            (rx_xid),
        .first_option_tag  (first_option_tag),
        .message_type      (message_type),
        .your_addr         (your_addr),
        .next_server_addr  (next_server_addr),
        .second_option_tag (second_option_tag),
        .server_id_option  (server_id_option),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .action            (action),
        .tx_xid            (tx_xid),
        .requested_addr    (requested_addr),
        .server_addr       (server_addr),
        .bound_addr        (bound_addr)
    );

    dhcp_client_handshake_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .op                (op),
        .ether_type        (ether_type),
        .ip_protocol       (ip_protocol),
        .udp_source_port   (udp_source_port),
        .boot_op           (boot_op),
        .rx_xid            (rx_xid),
        .first_option_tag  (first_option_tag),
        .message_type      (message_type),
        .your_addr         (your_addr),
        .next_server_addr  (next_server_addr),
        .second_option_tag (second_option_tag),
        .server_id_option  (server_id_option),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .action            (action),
        .tx_xid            (tx_xid),
        .requested_addr    (requested_addr),
        .server_addr       (server_addr),
        .bound_addr        (bound_addr),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .live_seen         (live_seen),
        .leases_bound      (leases_bound),
        .leases_failed     (leases_failed),
        .requests_sent     (requests_sent)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // After each accepted result the receiver may raise out_stall at random, unless calm is set.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else begin
            if (out_valid && !out_stall)
                stall_left = calm ? 0 : $urandom_range(0, 18);
            if (stall_left != 0) begin
                out_stall  <= 1'b1;
                stall_left = stall_left - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // A poll with every field random.
    function automatic dhcp_item_t noise_poll();
        dhcp_item_t it;
        it.op                = OP_POLL;
        it.ether_type        = 16'($urandom);
        it.ip_protocol       = 8'($urandom);
        it.udp_source_port   = 16'($urandom);
        it.boot_op           = 8'($urandom);
        it.rx_xid            = $urandom;
        it.first_option_tag  = 8'($urandom);
        it.message_type      = 8'($urandom);
        it.your_addr         = $urandom;
        it.next_server_addr  = $urandom;
        it.second_option_tag = 8'($urandom);
        it.server_id_option  = $urandom;
        return it;
    endfunction

    // A start request; its frame fields carry random junk.
    function automatic dhcp_item_t start_item();
        dhcp_item_t it;
        it    = noise_poll();
        it.op = OP_START;
        return it;
    endfunction

    // A poll that found no frame.
    function automatic dhcp_item_t empty_poll();
        dhcp_item_t it;
        it    = '{default: '0};
        it.op = OP_POLL;
        return it;
    endfunction

    // A well-formed server reply with random addresses.
    function automatic dhcp_item_t reply_item(input logic [31:0] xid,
                                              input logic [7:0] mtype);
        dhcp_item_t it;
        it.op                = OP_POLL;
        it.ether_type        = ETHERTYPE_IPV4;
        it.ip_protocol       = PROTO_UDP;
        it.udp_source_port   = PORT_SERVER;
        it.boot_op           = BOOT_REPLY;
        it.rx_xid            = xid;
        it.first_option_tag  = TAG_MSG_TYPE;
        it.message_type      = mtype;
        it.your_addr         = $urandom;
        it.next_server_addr  = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
        it.second_option_tag = ($urandom_range(0, 1) == 0) ? TAG_SERVER_ID
                                                           : 8'($urandom);
        it.server_id_option  = $urandom;
        return it;
    endfunction

    // A reply that fails exactly one of the frame checks or carries an unknown message type.
    function automatic dhcp_item_t broken_reply(input logic [31:0] xid,
                                                input logic [7:0] mtype);
        dhcp_item_t it;
        it = reply_item(xid, mtype);
        case ($urandom_range(0, 6))
            0: it.ether_type ^= 16'($urandom_range(1, 16'hFFFF));
            1: it.ip_protocol ^= 8'($urandom_range(1, 8'hFF));
            2: it.udp_source_port ^= 16'($urandom_range(1, 16'hFFFF));
            3: it.boot_op ^= 8'($urandom_range(1, 8'hFF));
            4: it.rx_xid ^= 32'd1 << $urandom_range(0, 31);
            5: it.first_option_tag ^= 8'($urandom_range(1, 8'hFF));
            default: it.message_type = 8'($urandom_range(7, 255));
        endcase
        return it;
    endfunction

    // A poll that must not decide the waiting phase.
    function automatic dhcp_item_t filler(input logic [31:0] xid,
                                          input logic [7:0] mtype,
                                          input logic [31:0] stale_xid);
        dhcp_item_t it;
        case ($urandom_range(0, 4))
            0: it = empty_poll();
            1: it = noise_poll();
            2: it = broken_reply(xid, mtype);
            3: begin
                // A right reply of the wrong kind for this phase.
                if (mtype == MSG_OFFER)
                    it = reply_item(xid, ($urandom_range(0, 1) == 0) ? MSG_ACK
                                                                     : MSG_NAK);
                else
                    it = reply_item(xid, MSG_OFFER);
            end
            default: it = reply_item(stale_xid, mtype);
        endcase
        return it;
    endfunction

    // Poll limit with the extremes weighted up and junk above bit 21.
    function automatic logic [CFG_DATA_W-1:0] pick_poll_limit();
        logic [POLL_W-1:0]            limit;
        logic [CFG_DATA_W-POLL_W-1:0] junk;
        case ($urandom_range(0, 9))
            0: limit = '0;
            1: limit = 1;
            2: limit = '1;
            3: limit = POLL_LIMIT_RESET;
            default: limit = POLL_W'($urandom_range(1, 6));
        endcase
        junk = ($urandom_range(0, 1) == 0) ? '0 : (CFG_DATA_W - POLL_W)'($urandom);
        return {junk, limit};
    endfunction

    // Present one request after a random gap and wait until it is taken.
    task automatic send_request(input dhcp_item_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        op                <= it.op;
        ether_type        <= it.ether_type;
        ip_protocol       <= it.ip_protocol;
        udp_source_port   <= it.udp_source_port;
        boot_op           <= it.boot_op;
        rx_xid            <= it.rx_xid;
        first_option_tag  <= it.first_option_tag;
        message_type      <= it.message_type;
        your_addr         <= it.your_addr;
        next_server_addr  <= it.next_server_addr;
        second_option_tag <= it.second_option_tag;
        server_id_option  <= it.server_id_option;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop sending and let every owed result come out.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_START_XID)
            start_xid_now = value;
        settings_written++;
    endtask

    // One transaction: Discover, noise, Offer, noise, Ack or Nak, with the
    // occasional abandoned start, zero address or mid-way limit change.
    task automatic run_transaction();
        logic [31:0] xid;
        dhcp_item_t  it;
        xid = start_xid_now;
        send_request(start_item());
        repeat ($urandom_range(0, 3)) send_request(filler(xid, MSG_OFFER, xid - 32'd1));
        if ($urandom_range(0, 9) != 0) begin
            it = reply_item(xid, MSG_OFFER);
            if ($urandom_range(0, 11) == 0)
                it.your_addr = '0;
            send_request(it);
            xid = xid + 32'd1;
            if ($urandom_range(0, 9) == 0) begin
                wait_idle();
                write_register(CFG_POLL_LIMIT, pick_poll_limit());
            end
            repeat ($urandom_range(0, 3))
                send_request(filler(xid, MSG_ACK, xid - 32'd1));
            it = reply_item(xid, ($urandom_range(0, 3) == 0) ? MSG_NAK : MSG_ACK);
            if ($urandom_range(0, 11) == 0)
                it.your_addr = '0;
            send_request(it);
            // A late reply once the transaction has ended is ignored.
            if ($urandom_range(0, 5) == 0)
                send_request(reply_item(xid, MSG_ACK));
        end
    endtask

    initial begin : stimulus
        dhcp_item_t it;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: polls while idle are ignored, then a full lease.
        send_request(reply_item(32'd0, MSG_OFFER));
        send_request(empty_poll());
        send_request(start_item());
        send_request(empty_poll());
        send_request(broken_reply(32'd0, MSG_OFFER));
        it = reply_item(32'd0, MSG_OFFER);
        it.next_server_addr = 32'hC0A8_0001;
        send_request(it);
        it = reply_item(32'd1, MSG_ACK);
        it.your_addr = 32'hFFFF_FFFF;
        send_request(it);
        wait_idle();

        // A limit of zero acts as one, and the id wraps past all ones.
        write_register(CFG_POLL_LIMIT, 32'hFFC0_0000);
        write_register(CFG_START_XID, 32'hFFFF_FFFF);
        send_request(start_item());
        send_request(empty_poll());
        send_request(start_item());
        it = reply_item(32'hFFFF_FFFF, MSG_OFFER);
        it.next_server_addr  = '0;
        it.second_option_tag = TAG_SERVER_ID;
        send_request(it);
        send_request(reply_item(32'd0, MSG_NAK));
        wait_idle();

        // Limit of two: zero offered address, no server identifier, zero
        // acked address, and a start that abandons a running transaction.
        write_register(CFG_POLL_LIMIT, 32'd2);
        write_register(CFG_START_XID, $urandom);
        send_request(start_item());
        it = reply_item(start_xid_now, MSG_OFFER);
        it.your_addr = '0;
        send_request(it);
        send_request(start_item());
        it = reply_item(start_xid_now, MSG_OFFER);
        it.next_server_addr  = '0;
        it.second_option_tag = TAG_MSG_TYPE;
        send_request(it);
        it = reply_item(start_xid_now + 32'd1, MSG_ACK);
        it.your_addr = '0;
        send_request(it);
        send_request(start_item());
        send_request(start_item());
        send_request(empty_poll());
        send_request(empty_poll());
        wait_idle();

        // Largest limit, then the limit drops while the Ack is awaited.
        write_register(CFG_POLL_LIMIT, {{(CFG_DATA_W - POLL_W){1'b0}}, {POLL_W{1'b1}}});
        send_request(start_item());
        send_request(reply_item(start_xid_now, MSG_OFFER));
        wait_idle();
        write_register(CFG_POLL_LIMIT, 32'd1);
        send_request(empty_poll());

        // Random phases, each with its own settings and pacing.
        while (live_seen < 1450) begin
            wait_idle();
            if ($urandom_range(0, 3) != 0)
                write_register(CFG_POLL_LIMIT, pick_poll_limit());
            if ($urandom_range(0, 3) != 0)
                write_register(CFG_START_XID,
                               ($urandom_range(0, 2) != 0) ? $urandom :
                               (($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF));
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 6)) run_transaction();
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Ran %0d live requests across %0d register writes, paced and back to back.",
                 live_seen, settings_written);
        $display("Outcomes: %0d DHCP Requests, %0d leases bound, %0d failures, %0d mismatches.",
                 requests_sent, leases_bound, leases_failed, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Give up if the run hangs.
    initial begin : watchdog
        #2_000_000;
        $display("Timeout with %0d results still owed.", outstanding);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/dhcp_pkg.sv
rtl/core/dhcp_reply_check.sv
rtl/core/dhcp_fsm.sv
rtl/core/dhcp_client_handshake.sv
sim/dhcp_client_handshake_checker.sv
sim/dhcp_client_handshake_tb.sv
